[rtl/core/bpa_pkg.sv]
// Shared types and constants for the bitmap page allocator.
package bpa_pkg;

  localparam int ADDR_W    = 32;
  localparam int ALU_W     = 35;
  localparam int MAP_W     = 64;
  localparam int BIT_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int REGION_W  = 64;
  localparam int KIND_W    = 32;

  localparam logic [ALU_W-1:0] KERNEL_MARGIN = ALU_W'(2048);
  localparam logic [ALU_W-1:0] ADDR_LIMIT    = ALU_W'(64'h1_0000_0000);
  localparam logic [KIND_W-1:0] KIND_AVAIL   = KIND_W'(1);

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_REGION = 2'd2,
    REQ_INIT   = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS = 2'd0,
    REG_KERN_LIMIT   = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_SUBM1
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_cmd_t;

endpackage

[rtl/core/bpa_ram.sv]
// Generic simple dual-port RAM with registered read.
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/bpa_alu.sv]
// Shared adder/subtractor used by the address and page-count arithmetic of the allocator.
module bpa_alu
  import bpa_pkg::*;
(
  input  alu_cmd_t         cmd,
  output logic [ALU_W-1:0] res
);

  always_comb begin
    case (cmd.op)
      ALU_ADD:   res = cmd.a + cmd.b;
      ALU_SUB:   res = cmd.a + ~cmd.b + ALU_W'(1);
      ALU_SUBM1: res = cmd.a + ~cmd.b;
      default:   res = cmd.a + cmd.b;
    endcase
  end

endmodule

[rtl/core/bitmap_page_allocator.sv]
// Bitmap page allocator top level: sequencer, map RAM and shared adder.
// The used map (one bit per page, 64 pages per RAM word) is walked through the map RAM at
// one word per cycle. After reset a clearing pass writes every word to all used while
// in_stall stays high; a begin-init request repeats that pass. An allocation scans the map
// words in order, stopping at the first word with a free page. A region request runs up to 11
// steps through the shared adder and then rewrites each map word it touches; a page free
// computes its page index through the adder and then clears its bit. One request is in flight at
// a time, and a finished result waits in the output register while the next request is taken.
module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int NUM_PAGES  = 65536,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_req_type,
  input  logic [ADDR_W-1:0]    in_page_address,
  input  logic [REGION_W-1:0]  in_region_start,
  input  logic [REGION_W-1:0]  in_region_length,
  input  logic [KIND_W-1:0]    in_region_kind,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_out_of_memory,
  output logic [ADDR_W-1:0]    out_granted_address,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  localparam int MAP_WORDS = (NUM_PAGES + MAP_W - 1) / MAP_W;
  localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IW        = WW + BIT_W;
  localparam logic [WW-1:0]    LAST_W   = WW'(MAP_WORDS - 1);
  localparam logic [ALU_W-1:0] NPAGES_A = ALU_W'(NUM_PAGES);
  localparam logic [ALU_W-1:0] PLAST_A  = ALU_W'(NUM_PAGES - 1);
  localparam logic [IW:0]      NPAGES_I = (IW+1)'(NUM_PAGES);
  localparam logic [IW-1:0]    PLAST_I  = IW'(NUM_PAGES - 1);
  localparam logic [ALU_W-1:0] PMASK    = ALU_W'((64'd1 << PAGE_SHIFT) - 64'd1);

  typedef enum logic [4:0] {
    S_FILL, S_IDLE, S_R_END, S_R_LEN, S_R_LO, S_R_LOB, S_R_DLT, S_R_KMIN, S_R_CHK,
    S_R_A0, S_R_P0, S_R_CNT, S_R_P1, S_FREE, S_SCAN, S_GRANT, S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic              ready_r, ready_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [ADDR_W-1:0] kend_r, kend_nxt;
  logic              fill_req_r, fill_req_nxt;
  logic [WW-1:0]     ptr_r, ptr_nxt;
  logic              iss_done_r, iss_done_nxt;
  logic              dv_r, dv_nxt;
  logic [WW-1:0]     dw_r, dw_nxt;
  logic [WW-1:0]     end_w_r, end_w_nxt;
  logic              alloc_mode_r, alloc_mode_nxt;
  logic [IW-1:0]     p0_r, p0_nxt;
  logic [IW-1:0]     p1_r, p1_nxt;
  logic [IW-1:0]     gidx_r, gidx_nxt;
  logic [ALU_W-1:0]  start_r, start_nxt;
  logic [ALU_W-1:0]  len_r, len_nxt;
  logic              len_big_r, len_big_nxt;
  logic [ADDR_W-1:0] page_r, page_nxt;
  logic [ALU_W-1:0]  end_r, end_nxt;
  logic [ALU_W-1:0]  kcnt_r, kcnt_nxt;
  logic [ALU_W-1:0]  lo_r, lo_nxt;
  logic [ALU_W-1:0]  kmin_r, kmin_nxt;
  logic [ALU_W-1:0]  acc_r, acc_nxt;
  logic              res_oom_r, res_oom_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_oom_r, out_oom_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;

  alu_cmd_t         alu_cmd;
  logic [ALU_W-1:0] alu_res;
  logic             alu_neg;

  logic             ram_we;
  logic [WW-1:0]    ram_waddr;
  logic [MAP_W-1:0] ram_wdata;
  logic             ram_re;
  logic [WW-1:0]    ram_raddr;
  logic [MAP_W-1:0] ram_rdata;

  logic [BIT_W-1:0] lo_b;
  logic [BIT_W-1:0] hi_b;
  logic [MAP_W-1:0] clr_mask;
  logic [BIT_W-1:0] free_b;
  logic [IW-1:0]    found_idx;
  logic             in_accept;

  bpa_alu u_alu (
    .cmd (alu_cmd),
    .res (alu_res)
  );

  bpa_ram #(
    .WIDTH (MAP_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign alu_neg   = alu_res[ALU_W-1];
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid           = out_valid_r;
  assign out_out_of_memory   = out_oom_r;
  assign out_granted_address = out_addr_r;

  assign lo_b     = (dw_r == p0_r[IW-1:BIT_W]) ? p0_r[BIT_W-1:0] : '0;
  assign hi_b     = (dw_r == end_w_r) ? p1_r[BIT_W-1:0] : '1;
  assign clr_mask = ({MAP_W{1'b1}} << lo_b) & ({MAP_W{1'b1}} >> (~hi_b));

  always_comb begin
    free_b = '0;
    for (int b = MAP_W - 1; b >= 0; b--) begin
      if (!ram_rdata[b]) begin
        free_b = BIT_W'(b);
      end
    end
  end

  assign found_idx = {dw_r, free_b};

  always_comb begin
    state_nxt      = state_r;
    ready_nxt      = ready_r;
    base_nxt       = base_r;
    kend_nxt       = kend_r;
    fill_req_nxt   = fill_req_r;
    ptr_nxt        = ptr_r;
    iss_done_nxt   = iss_done_r;
    dv_nxt         = 1'b0;
    dw_nxt         = dw_r;
    end_w_nxt      = end_w_r;
    alloc_mode_nxt = alloc_mode_r;
    p0_nxt         = p0_r;
    p1_nxt         = p1_r;
    gidx_nxt       = gidx_r;
    start_nxt      = start_r;
    len_nxt        = len_r;
    len_big_nxt    = len_big_r;
    page_nxt       = page_r;
    end_nxt        = end_r;
    kcnt_nxt       = kcnt_r;
    lo_nxt         = lo_r;
    kmin_nxt       = kmin_r;
    acc_nxt        = acc_r;
    res_oom_nxt    = res_oom_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_oom_nxt    = out_oom_r;
    out_addr_nxt   = out_addr_r;
    alu_cmd        = '{op: ALU_ADD, a: '0, b: '0};
    ram_we         = 1'b0;
    ram_waddr      = dw_r;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = ptr_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_ADDRESS: base_nxt = cfg_data;
        REG_KERN_LIMIT:   kend_nxt = cfg_data;
        default:          ;
      endcase
    end

    case (state_r)
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = '1;
        ptr_nxt   = ptr_r + WW'(1);
        if (ptr_r == LAST_W) begin
          state_nxt = fill_req_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          res_oom_nxt  = 1'b0;
          res_addr_nxt = '0;
          start_nxt    = {2'b00, in_region_start[ALU_W-3:0]};
          len_nxt      = {2'b00, in_region_length[ALU_W-3:0]};
          len_big_nxt  = |in_region_length[REGION_W-1:ALU_W-2];
          page_nxt     = in_page_address;
          iss_done_nxt = 1'b0;
          case (req_t'(in_req_type))
            REQ_ALLOC: begin
              if (ready_r) begin
                alloc_mode_nxt = 1'b1;
                ptr_nxt        = '0;
                end_w_nxt      = LAST_W;
                state_nxt      = S_SCAN;
              end else begin
                res_oom_nxt = 1'b1;
                state_nxt   = S_DONE;
              end
            end
            REQ_FREE: begin
              state_nxt = ready_r ? S_FREE : S_DONE;
            end
            REQ_REGION: begin
              if (in_region_kind == KIND_AVAIL && ~|in_region_start[REGION_W-1:ALU_W-2]) begin
                state_nxt = S_R_END;
              end else begin
                state_nxt = S_DONE;
              end
            end
            REQ_INIT: begin
              ready_nxt    = 1'b1;
              fill_req_nxt = 1'b1;
              ptr_nxt      = '0;
              state_nxt    = S_FILL;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_R_END: begin
        alu_cmd   = '{op: ALU_ADD, a: start_r, b: len_r};
        end_nxt   = (len_big_r || |alu_res[ALU_W-1:ADDR_W]) ? ADDR_LIMIT : alu_res;
        state_nxt = S_R_LEN;
      end
      S_R_LEN: begin
        alu_cmd  = '{op: ALU_SUB, a: end_r, b: start_r};
        kcnt_nxt = alu_res >> PAGE_SHIFT;
        if (alu_neg || (alu_res >> PAGE_SHIFT) == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_R_LO;
        end
      end
      S_R_LO: begin
        alu_cmd   = '{op: ALU_ADD, a: ALU_W'(kend_r), b: KERNEL_MARGIN};
        lo_nxt    = alu_res;
        state_nxt = S_R_LOB;
      end
      S_R_LOB: begin
        alu_cmd = '{op: ALU_SUB, a: lo_r, b: ALU_W'(base_r)};
        if (alu_neg) begin
          lo_nxt = ALU_W'(base_r);
        end
        state_nxt = S_R_DLT;
      end
      S_R_DLT: begin
        alu_cmd = '{op: ALU_SUB, a: lo_r, b: start_r};
        if (alu_neg || alu_res == '0) begin
          kmin_nxt  = '0;
          state_nxt = S_R_CHK;
        end else begin
          acc_nxt   = alu_res;
          state_nxt = S_R_KMIN;
        end
      end
      S_R_KMIN: begin
        alu_cmd   = '{op: ALU_ADD, a: acc_r >> PAGE_SHIFT, b: ALU_W'(|(acc_r & PMASK))};
        kmin_nxt  = alu_res;
        state_nxt = S_R_CHK;
      end
      S_R_CHK: begin
        alu_cmd   = '{op: ALU_SUB, a: kmin_r, b: kcnt_r};
        state_nxt = alu_neg ? S_R_A0 : S_DONE;
      end
      S_R_A0: begin
        alu_cmd   = '{op: ALU_ADD, a: start_r, b: ALU_W'(kmin_r << PAGE_SHIFT)};
        acc_nxt   = alu_res;
        state_nxt = S_R_P0;
      end
      S_R_P0: begin
        alu_cmd = '{op: ALU_SUB, a: acc_r, b: ALU_W'(base_r)};
        p0_nxt  = IW'(alu_res >> PAGE_SHIFT);
        if ((alu_res >> PAGE_SHIFT) >= NPAGES_A) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_R_CNT;
        end
      end
      S_R_CNT: begin
        alu_cmd   = '{op: ALU_SUBM1, a: kcnt_r, b: kmin_r};
        acc_nxt   = alu_res;
        state_nxt = S_R_P1;
      end
      S_R_P1: begin
        alu_cmd = '{op: ALU_ADD, a: ALU_W'(p0_r), b: acc_r};
        if (alu_res >= PLAST_A) begin
          p1_nxt = PLAST_I;
        end else begin
          p1_nxt = IW'(alu_res);
        end
        end_w_nxt      = p1_nxt[IW-1:BIT_W];
        ptr_nxt        = p0_r[IW-1:BIT_W];
        alloc_mode_nxt = 1'b0;
        state_nxt      = S_SCAN;
      end
      S_FREE: begin
        alu_cmd = '{op: ALU_SUB, a: ALU_W'(page_r), b: ALU_W'(base_r)};
        p0_nxt  = IW'(alu_res >> PAGE_SHIFT);
        p1_nxt  = IW'(alu_res >> PAGE_SHIFT);
        end_w_nxt      = p0_nxt[IW-1:BIT_W];
        ptr_nxt        = p0_nxt[IW-1:BIT_W];
        alloc_mode_nxt = 1'b0;
        if (alu_neg || (alu_res >> PAGE_SHIFT) >= NPAGES_A) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!iss_done_r) begin
          ram_re = 1'b1;
          dv_nxt = 1'b1;
          dw_nxt = ptr_r;
          if (ptr_r == end_w_r) begin
            iss_done_nxt = 1'b1;
          end else begin
            ptr_nxt = ptr_r + WW'(1);
          end
        end
        if (dv_r) begin
          if (alloc_mode_r) begin
            if (~&ram_rdata) begin
              if ({1'b0, found_idx} >= NPAGES_I) begin
                res_oom_nxt = 1'b1;
                state_nxt   = S_DONE;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | (MAP_W'(1) << free_b);
                gidx_nxt  = found_idx;
                state_nxt = S_GRANT;
              end
            end else if (dw_r == end_w_r) begin
              res_oom_nxt = 1'b1;
              state_nxt   = S_DONE;
            end
          end else begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~clr_mask;
            if (dw_r == end_w_r) begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_GRANT: begin
        alu_cmd = '{op: ALU_ADD, a: ALU_W'(base_r),
                    b: ALU_W'(ADDR_W'(64'(gidx_r) << PAGE_SHIFT))};
        res_addr_nxt = alu_res[ADDR_W-1:0];
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        fill_req_nxt = 1'b0;
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_oom_nxt   = res_oom_r;
          out_addr_nxt  = res_addr_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_FILL;
      ready_r      <= 1'b0;
      base_r       <= '0;
      kend_r       <= '0;
      fill_req_r   <= 1'b0;
      ptr_r        <= '0;
      iss_done_r   <= 1'b0;
      dv_r         <= 1'b0;
      alloc_mode_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ready_r      <= ready_nxt;
      base_r       <= base_nxt;
      kend_r       <= kend_nxt;
      fill_req_r   <= fill_req_nxt;
      ptr_r        <= ptr_nxt;
      iss_done_r   <= iss_done_nxt;
      dv_r         <= dv_nxt;
      alloc_mode_r <= alloc_mode_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    dw_r       <= dw_nxt;
    end_w_r    <= end_w_nxt;
    p0_r       <= p0_nxt;
    p1_r       <= p1_nxt;
    gidx_r     <= gidx_nxt;
    start_r    <= start_nxt;
    len_r      <= len_nxt;
    len_big_r  <= len_big_nxt;
    page_r     <= page_nxt;
    end_r      <= end_nxt;
    kcnt_r     <= kcnt_nxt;
    lo_r       <= lo_nxt;
    kmin_r     <= kmin_nxt;
    acc_r      <= acc_nxt;
    res_oom_r  <= res_oom_nxt;
    res_addr_r <= res_addr_nxt;
    out_oom_r  <= out_oom_nxt;
    out_addr_r <= out_addr_nxt;
  end

endmodule

[rtl/core/bpa_checker.sv]
// Port-level assertions for the bitmap page allocator, bound to the top level.
module bpa_checker
  import bpa_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_out_of_memory,
  input logic [ADDR_W-1:0] out_granted_address
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled request dropped");

  a_oom_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_memory |-> out_granted_address == '0)
    else $error("failed allocation carries an address");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one still in progress");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("request taken during map clearing pass");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_out_of_memory   (out_out_of_memory),
  .out_granted_address (out_granted_address)
);

[tb/bitmap_page_allocator_tb.sv]
// Self-checking testbench for the bitmap page allocator against a page map model.
`timescale 1ns / 1ps

module bitmap_page_allocator_tb;
  import bpa_pkg::*;

  localparam int NUM_PAGES = 65536;
  localparam int PAGE_SHIFT = 12;
  localparam int MAP_WORDS = NUM_PAGES / 64;
  localparam logic [63:0] PAGE_BYTES = 64'd1 << PAGE_SHIFT;
  localparam logic [63:0] MARGIN = 64'd2048;
  localparam logic [63:0] SPACE_TOP = 64'h1_0000_0000;
  localparam int LONG_HOLD = 600;

  typedef struct {
    bit        oom;
    bit [31:0] addr;
  } grant_t;

  class page_map_tracker;
    bit [63:0] map_words [MAP_WORDS];
    bit        ready;
    bit [31:0] base_addr;
    bit [31:0] kern_limit;
    grant_t    grants_due [$];
    int        errors;

    function new();
      mark_all_used();
      ready = 1'b0;
      base_addr = '0;
      kern_limit = '0;
      errors = 0;
    endfunction

    function void mark_all_used();
      foreach (map_words[i]) map_words[i] = '1;
    endfunction

    function void clear_page(bit [63:0] idx);
      if (idx < NUM_PAGES) map_words[int'(idx >> 6)][idx[5:0]] = 1'b0;
    endfunction

    function void set_reg(cfg_reg_t idx, bit [31:0] value);
      case (idx)
        REG_BASE_ADDRESS: base_addr = value;
        REG_KERN_LIMIT:   kern_limit = value;
        default: ;
      endcase
    endfunction

    function void note_request(req_t rt, bit [31:0] pa, bit [63:0] rs, bit [63:0] rl,
                               bit [31:0] rk);
      grant_t    g;
      bit [64:0] sum;
      bit [63:0] rend, lo, kmin, kmax, a0, p0, p1, p;
      int        w, b;
      g.oom = 1'b0;
      g.addr = '0;
      case (rt)
        REQ_ALLOC: begin
          g.oom = 1'b1;
          if (ready) begin
            for (w = 0; w < MAP_WORDS && g.oom; w++) begin
              if (map_words[w] != '1) begin
                for (b = 0; b < 64 && g.oom; b++) begin
                  if (!map_words[w][b]) begin
                    map_words[w][b] = 1'b1;
                    g.oom = 1'b0;
                    g.addr = base_addr + (32'(w * 64 + b) << PAGE_SHIFT);
                  end
                end
              end
            end
          end
        end
        REQ_FREE: begin
          if (ready && pa >= base_addr) clear_page(64'((pa - base_addr) >> PAGE_SHIFT));
        end
        REQ_REGION: begin
          if (rk == KIND_AVAIL) begin
            sum = {1'b0, rs} + {1'b0, rl};
            rend = sum[64] ? '1 : sum[63:0];
            if (rend > SPACE_TOP) rend = SPACE_TOP;
            lo = 64'(kern_limit) + MARGIN;
            if (lo < 64'(base_addr)) lo = 64'(base_addr);
            if (rend >= rs && rend - rs >= PAGE_BYTES) begin
              kmax = (rend - rs - PAGE_BYTES) >> PAGE_SHIFT;
              kmin = (rs >= lo) ? 64'd0 : (lo - rs + PAGE_BYTES - 64'd1) >> PAGE_SHIFT;
              a0 = rs + (kmin << PAGE_SHIFT);
              p0 = (a0 - 64'(base_addr)) >> PAGE_SHIFT;
              if (kmin <= kmax && p0 < NUM_PAGES) begin
                p1 = p0 + (kmax - kmin);
                if (p1 >= NUM_PAGES) p1 = 64'(NUM_PAGES - 1);
                for (p = p0; p <= p1; p++) clear_page(p);
              end
            end
          end
        end
        REQ_INIT: begin
          mark_all_used();
          ready = 1'b1;
        end
        default: ;
      endcase
      grants_due.push_back(g);
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_grant(logic oom, logic [31:0] addr);
      grant_t g;
      if (grants_due.size() == 0) begin
        report("result arrived with no request pending");
        return;
      end
      g = grants_due.pop_front();
      if (oom !== g.oom) report($sformatf("out_of_memory %0b, predicted %0b", oom, g.oom));
      if (addr !== g.addr) report($sformatf("granted_address %h, predicted %h", addr, g.addr));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_req_type;
  logic [ADDR_W-1:0]    in_page_address;
  logic [REGION_W-1:0]  in_region_start;
  logic [REGION_W-1:0]  in_region_length;
  logic [KIND_W-1:0]    in_region_kind;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_out_of_memory;
  logic [ADDR_W-1:0]    out_granted_address;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  page_map_tracker sb;
  int              sent;
  bit              tx_quiet;

  bitmap_page_allocator #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_page_address    (in_page_address),
    .in_region_start    (in_region_start),
    .in_region_length   (in_region_length),
    .in_region_kind     (in_region_kind),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_out_of_memory  (out_out_of_memory),
    .out_granted_address(out_granted_address),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit [63:0] junk64();
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(cfg_reg_t idx, bit [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic issue(req_t rt, bit [31:0] pa, bit [63:0] rs, bit [63:0] rl, bit [31:0] rk,
                       bit last = 1'b0);
    int gap;
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_page_address <= pa;
    in_region_start <= rs;
    in_region_length <= rl;
    in_region_kind <= rk;
    do @(posedge clk); while (in_stall);
    sb.note_request(rt, pa, rs, rl, rk);
    sent++;
    if (sent % 32 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (last && gap == 0) gap = 1;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_items(int count);
    req_t      rt;
    bit [31:0] pa, rk;
    bit [63:0] rs, rl, floor_addr;
    int        sel, i;
    issue(REQ_INIT, $urandom, junk64(), junk64(), $urandom);
    for (i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      pa = $urandom;
      rs = junk64();
      rl = junk64();
      rk = $urandom;
      floor_addr = 64'(sb.kern_limit) + MARGIN;
      if (floor_addr < 64'(sb.base_addr)) floor_addr = 64'(sb.base_addr);
      if (sel < 3) begin
        rt = REQ_INIT;
      end else if (sel < 30) begin
        rt = REQ_REGION;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
          rs = floor_addr + (64'($urandom_range(0, 200)) << PAGE_SHIFT);
          if ($urandom_range(0, 3) == 0) rs += $urandom_range(1, 4095);
          rl = 64'($urandom_range(1, 48)) << PAGE_SHIFT;
          if ($urandom_range(0, 3) == 0) rl += $urandom_range(0, 4095);
          rk = ($urandom_range(0, 9) == 0) ? $urandom : KIND_AVAIL;
        end else if (sel < 8) begin
          rs = 64'(sb.base_addr) + (64'($urandom_range(0, NUM_PAGES - 1)) << PAGE_SHIFT);
          rl = 64'($urandom_range(0, 16)) << PAGE_SHIFT;
          rk = KIND_AVAIL;
        end else if (sel == 8) begin
          rs = 64'($urandom);
          rk = KIND_AVAIL;
        end
      end else if (sel < 60) begin
        rt = REQ_FREE;
        if ($urandom_range(0, 9) < 7)
          pa = sb.base_addr + ($urandom_range(0, 255) << PAGE_SHIFT) + $urandom_range(0, 4095);
      end else begin
        rt = REQ_ALLOC;
      end
      issue(rt, pa, rs, rl, rk, i == count - 1);
    end
  endtask

  task automatic drain();
    while (sb.grants_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    bit [31:0] rand_base;
    sb = new();
    sent = 0;
    tx_quiet = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= REQ_ALLOC;
    in_page_address <= '0;
    in_region_start <= '0;
    in_region_length <= '0;
    in_region_kind <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_BASE_ADDRESS;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(REG_BASE_ADDRESS, 32'h0001_0000);
    write_reg(REG_KERN_LIMIT, 32'h0004_0000);
    issue(REQ_ALLOC, $urandom, junk64(), junk64(), $urandom);
    issue(REQ_FREE, 32'h0001_2000, junk64(), junk64(), $urandom);
    issue(REQ_REGION, $urandom, 64'h5_0000, 64'h8000, KIND_AVAIL);
    issue(REQ_INIT, $urandom, junk64(), junk64(), $urandom);
    issue(REQ_REGION, $urandom, 64'h3_8000, 64'h2_0000, KIND_AVAIL);
    issue(REQ_ALLOC, $urandom, junk64(), junk64(), $urandom);
    issue(REQ_ALLOC, $urandom, junk64(), junk64(), $urandom);
    issue(REQ_FREE, 32'h0004_1abc, junk64(), junk64(), $urandom);
    issue(REQ_ALLOC, $urandom, junk64(), junk64(), $urandom);
    issue(REQ_FREE, 32'h0000_f000, junk64(), junk64(), $urandom);
    issue(REQ_FREE, 32'hffff_ffff, junk64(), junk64(), $urandom);
    issue(REQ_REGION, $urandom, 64'h8_0000, 64'h4000, 32'd0);
    issue(REQ_REGION, $urandom, 64'h8_0000, 64'h4000, 32'hffff_ffff);
    issue(REQ_REGION, $urandom, 64'h1_0000_0000, 64'h1_0000, KIND_AVAIL);
    issue(REQ_REGION, $urandom, 64'h9_0000, 64'h0, KIND_AVAIL);
    issue(REQ_REGION, $urandom, 64'h9_0000, 64'hfff, KIND_AVAIL);
    issue(REQ_REGION, $urandom, 64'h6_0123, 64'h3000, KIND_AVAIL);
    issue(REQ_REGION, $urandom, 64'hffff_ffff_ffff_0000, 64'h2_0000, KIND_AVAIL);
    issue(REQ_REGION, $urandom, 64'h1000_e000, 64'h4000, KIND_AVAIL);
    issue(REQ_ALLOC, $urandom, junk64(), junk64(), $urandom);
    issue(REQ_INIT, $urandom, junk64(), junk64(), $urandom);
    issue(REQ_ALLOC, $urandom, junk64(), junk64(), $urandom);
    issue(REQ_REGION, $urandom, 64'h1000_f000, 64'h1000, KIND_AVAIL);
    issue(REQ_ALLOC, $urandom, junk64(), junk64(), $urandom);
    issue(REQ_REGION, $urandom, 64'h0110_0000, '1, KIND_AVAIL);
    issue(REQ_ALLOC, $urandom, junk64(), junk64(), $urandom);
    random_items(115);
    drain();

    write_reg(REG_BASE_ADDRESS, 32'h0000_0000);
    write_reg(REG_KERN_LIMIT, 32'h0000_0000);
    random_items(125);
    drain();

    write_reg(REG_BASE_ADDRESS, 32'hffff_ffff);
    write_reg(REG_KERN_LIMIT, 32'hffff_ffff);
    random_items(85);
    drain();

    write_reg(REG_BASE_ADDRESS, 32'hfff0_0000);
    write_reg(REG_KERN_LIMIT, 32'h0000_0000);
    random_items(105);
    drain();

    rand_base = $urandom & 32'h3fff_ffff;
    write_reg(REG_BASE_ADDRESS, rand_base);
    write_reg(REG_KERN_LIMIT, rand_base + $urandom_range(0, 32'h0010_0000));
    random_items(125);
    drain();

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int hold;
    int seen;
    bit rx_quiet;
    seen = 0;
    rx_quiet = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = rx_quiet ? 0 : $urandom_range(0, 16);
      if (seen == 120) hold = LONG_HOLD;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      sb.check_grant(out_out_of_memory, out_granted_address);
      seen++;
      if (seen % 32 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
